// ===== rtl/core/adam_pu_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// adam_pu_pkg
// Shared types and constants of the Adam parameter update unit.
// ----------------------------------------------------------------------------
package adam_pu_pkg;

  localparam int unsigned IDX_W  = 12;
  localparam int unsigned DATA_W = 32;

  // register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_BETA_ONE      = 2'd0;
  localparam logic [1:0] REG_BETA_TWO      = 2'd1;
  localparam logic [1:0] REG_EPSILON       = 2'd2;
  localparam logic [1:0] REG_LEARNING_RATE = 2'd3;

  localparam logic [15:0] BETA_ONE_RST      = 16'd58982;
  localparam logic [15:0] BETA_TWO_RST      = 16'd65470;
  localparam logic [24:0] EPSILON_RST       = 25'd1;
  localparam logic [23:0] LEARNING_RATE_RST = 24'd16777;

  // 1.0 in unsigned Q1.31
  localparam logic [31:0] ONE_Q31  = 32'h8000_0000;
  // step clamp, 2^33
  localparam logic [33:0] STEP_MAX = 34'h2_0000_0000;

  typedef struct packed {
    logic [IDX_W-1:0]         param_index;
    logic signed [DATA_W-1:0] error_term;
    logic signed [DATA_W-1:0] activation;
    logic signed [DATA_W-1:0] weight_in;
    logic                     first_of_pass;
  } in_word_t;

  typedef struct packed {
    logic [IDX_W-1:0]         index_out;
    logic signed [DATA_W-1:0] weight_out;
  } out_word_t;

  typedef struct packed {
    logic [15:0] beta_one;
    logic [15:0] beta_two;
    logic [24:0] epsilon;
    logic [23:0] learning_rate;
  } cfg_t;

  // updated moments leaving the front end
  typedef struct packed {
    logic                     vld;
    logic [IDX_W-1:0]         idx;
    logic signed [DATA_W-1:0] w;
    logic signed [DATA_W-1:0] m;
    logic [DATA_W-1:0]        v;
    logic [31:0]              d1;
    logic [31:0]              d2;
  } front_t;

endpackage
`default_nettype wire

// ===== rtl/core/adam_parameter_update_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// adam_parameter_update_unit
// Streaming Adam optimizer step over fixed point parameters.
// ----------------------------------------------------------------------------
// Input words carry a parameter index, error term, activation, current weight
// and a first-of-pass flag; each returns one word with the index and the new
// weight. Both channels are valid/ready. The APB port holds beta_one,
// beta_two, epsilon and learning_rate; the user must write it only while idle,
// the block does not enforce this. Throughput: one word per cycle unless
// stalled or clearing. A word passes the bias-correction dividers (63 stages),
// the square root (32 stages), the step divider (64 stages) and seven more
// register stages. Moment stores sit in two synchronous RAMs; the word behind
// a write to the same index takes the fresh value from a forwarding path.
// After reset the moment RAMs are cleared, one entry a cycle; in_ready_o stays
// low until then, configuration writes still work. When the receiver stalls
// the whole pipeline holds and in_ready_o drops.
// ----------------------------------------------------------------------------
module adam_parameter_update_unit #(
  parameter int unsigned PARAM_COUNT = 4096,
  parameter int unsigned FRAC_BITS   = 24
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  adam_pu_pkg::in_word_t  in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output adam_pu_pkg::out_word_t out_data_o,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [3:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam int unsigned IW  = adam_pu_pkg::IDX_W;
  localparam int unsigned LSH = (FRAC_BITS >= 24) ? FRAC_BITS - 24 : 0;
  localparam int unsigned RSH = (FRAC_BITS < 24) ? 24 - FRAC_BITS : 0;
  localparam logic [63:0] VHAT_MAX = 64'hFFFF_FFFF_FFFF_FFFF >> FRAC_BITS;

  typedef struct packed {
    logic [IW-1:0]      idx;
    logic signed [31:0] w;
    logic               neg;
  } item_t;

  typedef struct packed {
    item_t       item;
    logic [39:0] mhat;
  } sq_tag_t;

  logic adv, fire, busy;
  logic out_valid_q;

  assign adv        = !out_valid_q | out_ready_i;
  assign in_ready_o = adv & !busy;
  assign fire       = in_valid_i & in_ready_o;

  // configuration registers
  adam_pu_pkg::cfg_t cfg_q;
  logic              cfg_we;

  assign cfg_we = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.beta_one      <= adam_pu_pkg::BETA_ONE_RST;
      cfg_q.beta_two      <= adam_pu_pkg::BETA_TWO_RST;
      cfg_q.epsilon       <= adam_pu_pkg::EPSILON_RST;
      cfg_q.learning_rate <= adam_pu_pkg::LEARNING_RATE_RST;
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        adam_pu_pkg::REG_BETA_ONE:      cfg_q.beta_one      <= pwdata[15:0];
        adam_pu_pkg::REG_BETA_TWO:      cfg_q.beta_two      <= pwdata[15:0];
        adam_pu_pkg::REG_EPSILON:       cfg_q.epsilon       <= pwdata[24:0];
        adam_pu_pkg::REG_LEARNING_RATE: cfg_q.learning_rate <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      adam_pu_pkg::REG_BETA_ONE:      prdata = 32'(cfg_q.beta_one);
      adam_pu_pkg::REG_BETA_TWO:      prdata = 32'(cfg_q.beta_two);
      adam_pu_pkg::REG_EPSILON:       prdata = 32'(cfg_q.epsilon);
      adam_pu_pkg::REG_LEARNING_RATE: prdata = 32'(cfg_q.learning_rate);
      default:                        prdata = '0;
    endcase
  end

  // running beta powers, advanced on a first-of-pass word
  logic [31:0] pow1_q, pow2_q;
  logic [47:0] pp1, pp2;
  logic [31:0] pow1_sel, pow2_sel, d1, d2;

  always_comb begin
    pp1      = pow1_q * cfg_q.beta_one;
    pp2      = pow2_q * cfg_q.beta_two;
    pow1_sel = in_data_i.first_of_pass ? pp1[47:16] : pow1_q;
    pow2_sel = in_data_i.first_of_pass ? pp2[47:16] : pow2_q;
    d1       = adam_pu_pkg::ONE_Q31 - pow1_sel;
    d2       = adam_pu_pkg::ONE_Q31 - pow2_sel;
    // no step yet: no bias correction
    if (d1 == '0) d1 = adam_pu_pkg::ONE_Q31;
    if (d2 == '0) d2 = adam_pu_pkg::ONE_Q31;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pow1_q <= adam_pu_pkg::ONE_Q31;
      pow2_q <= adam_pu_pkg::ONE_Q31;
    end else if (fire && in_data_i.first_of_pass) begin
      pow1_q <= pp1[47:16];
      pow2_q <= pp2[47:16];
    end
  end

  // gradient and moment stores
  adam_pu_pkg::front_t front;

  adam_pu_moment #(
    .PARAM_COUNT(PARAM_COUNT),
    .FRAC_BITS  (FRAC_BITS)
  ) u_moment (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .fire_i    (fire),
    .word_i    (in_data_i),
    .d1_i      (d1),
    .d2_i      (d2),
    .beta_one_i(cfg_q.beta_one),
    .beta_two_i(cfg_q.beta_two),
    .busy_o    (busy),
    .front_o   (front)
  );

  // stage C: magnitude of the first moment
  logic        c_vld_q;
  item_t       c_item_q;
  logic [31:0] c_mag_q, c_v_q, c_d1_q, c_d2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) c_vld_q <= 1'b0;
    else if (adv) c_vld_q <= front.vld;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c_item_q.idx <= front.idx;
      c_item_q.w   <= front.w;
      c_item_q.neg <= front.m < 0;
      c_mag_q      <= (front.m < 0) ? 32'(-front.m) : 32'(front.m);
      c_v_q        <= front.v;
      c_d1_q       <= front.d1;
      c_d2_q       <= front.d2;
    end
  end

  // bias correction dividers
  logic          dv1_vld, dv2_vld;
  logic [62:0]   dv1_quo, dv2_quo;
  logic [IW-1:0] dv1_tag;
  logic [32:0]   dv2_tag;

  adam_pu_div #(.NW(63), .DW(32), .TW(IW)) u_div_m (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (adv),
    .vld_i (c_vld_q),
    .num_i ({c_mag_q, 31'b0}),
    .den_i (c_d1_q),
    .tag_i (c_item_q.idx),
    .vld_o (dv1_vld),
    .quo_o (dv1_quo),
    .tag_o (dv1_tag)
  );

  adam_pu_div #(.NW(63), .DW(32), .TW(33)) u_div_v (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (adv),
    .vld_i (c_vld_q),
    .num_i ({c_v_q, 31'b0}),
    .den_i (c_d2_q),
    .tag_i ({c_item_q.w, c_item_q.neg}),
    .vld_o (dv2_vld),
    .quo_o (dv2_quo),
    .tag_o (dv2_tag)
  );

  // stage D: saturate corrected moments
  logic        d_vld_q;
  sq_tag_t     d_tag_q;
  logic [63:0] d_x_q;
  logic [63:0] vhat;

  assign vhat = (64'(dv2_quo) > VHAT_MAX) ? VHAT_MAX : 64'(dv2_quo);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) d_vld_q <= 1'b0;
    else if (adv) d_vld_q <= dv1_vld & dv2_vld;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d_tag_q.item.idx <= dv1_tag;
      d_tag_q.item.w   <= dv2_tag[32:1];
      d_tag_q.item.neg <= dv2_tag[0];
      d_tag_q.mhat     <= (dv1_quo[62:40] != '0) ? 40'hFF_FFFF_FFFF : dv1_quo[39:0];
      d_x_q            <= vhat << FRAC_BITS;
    end
  end

  // root of the corrected second moment
  logic        sq_vld;
  logic [31:0] sq_root;
  sq_tag_t     sq_tag;

  adam_pu_sqrt #(.TW($bits(sq_tag_t))) u_sqrt (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (adv),
    .vld_i (d_vld_q),
    .x_i   (d_x_q),
    .tag_i (d_tag_q),
    .vld_o (sq_vld),
    .root_o(sq_root),
    .tag_o (sq_tag)
  );

  // stage E: denominator and partial products of lr * mhat
  logic        e_vld_q;
  item_t       e_item_q;
  logic [32:0] e_den_q;
  logic [55:0] e_plo_q;
  logic [31:0] e_phi_q;
  logic [32:0] den;

  always_comb begin
    den = 33'(sq_root) + 33'(cfg_q.epsilon);
    if (den == '0) den = 33'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) e_vld_q <= 1'b0;
    else if (adv) e_vld_q <= sq_vld;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e_item_q <= sq_tag.item;
      e_den_q  <= den;
      e_plo_q  <= cfg_q.learning_rate * sq_tag.mhat[31:0];
      e_phi_q  <= cfg_q.learning_rate * sq_tag.mhat[39:32];
    end
  end

  // stage F: full numerator
  logic        f_vld_q;
  item_t       f_item_q;
  logic [32:0] f_den_q;
  logic [63:0] f_num_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) f_vld_q <= 1'b0;
    else if (adv) f_vld_q <= e_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      f_item_q <= e_item_q;
      f_den_q  <= e_den_q;
      f_num_q  <= {e_phi_q, 32'b0} + 64'(e_plo_q);
    end
  end

  // step divider
  logic        dq_vld;
  logic [63:0] dq_quo;
  item_t       dq_item;

  adam_pu_div #(.NW(64), .DW(33), .TW($bits(item_t))) u_div_q (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .en_i  (adv),
    .vld_i (f_vld_q),
    .num_i (f_num_q),
    .den_i (f_den_q),
    .tag_i (f_item_q),
    .vld_o (dq_vld),
    .quo_o (dq_quo),
    .tag_o (dq_item)
  );

  // step clamp, rescale, apply and saturate
  logic [33:0]        q1, q2;
  logic [39:0]        qs;
  logic signed [35:0] wsum;
  logic signed [31:0] w_new;

  always_comb begin
    q1   = (dq_quo > 64'(adam_pu_pkg::STEP_MAX)) ? adam_pu_pkg::STEP_MAX : dq_quo[33:0];
    qs   = (40'(q1) << LSH) >> RSH;
    q2   = (qs > 40'(adam_pu_pkg::STEP_MAX)) ? adam_pu_pkg::STEP_MAX : qs[33:0];
    wsum = dq_item.neg ? 36'(dq_item.w) + signed'({2'b00, q2})
                       : 36'(dq_item.w) - signed'({2'b00, q2});
    if (wsum > 36'sd2147483647)       w_new = 32'sh7FFF_FFFF;
    else if (wsum < -36'sd2147483648) w_new = 32'sh8000_0000;
    else                              w_new = wsum[31:0];
  end

  // output register
  adam_pu_pkg::out_word_t out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (adv) out_valid_q <= dq_vld;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q.index_out  <= dq_item.idx;
      out_data_q.weight_out <= w_new;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // checks
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !in_ready_o)
    else $error("word accepted during moment clear");

  a_pow_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(fire && in_data_i.first_of_pass) |=> (pow1_q == $past(pow1_q)) &&
                                           (pow2_q == $past(pow2_q)))
    else $error("beta power moved without a first-of-pass word");

  a_pow_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pow1_q <= adam_pu_pkg::ONE_Q31) && (pow2_q <= adam_pu_pkg::ONE_Q31))
    else $error("beta power above one");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    c_vld_q |-> (c_d1_q != '0) && (c_d2_q != '0))
    else $error("zero bias correction divisor");

endmodule
`default_nettype wire

// ===== rtl/core/adam_pu_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// adam_pu_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module adam_pu_div #(
  parameter int unsigned NW = 64,
  parameter int unsigned DW = 32,
  parameter int unsigned TW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [TW-1:0] tag_i,
  output logic          vld_o,
  output logic [NW-1:0] quo_o,
  output logic [TW-1:0] tag_o
);

  logic          vld_q [NW];
  logic [DW-1:0] rem_q [NW];
  logic [NW-1:0] num_q [NW];
  logic [NW-1:0] quo_q [NW];
  logic [DW-1:0] den_q [NW];
  logic [TW-1:0] tag_q [NW];

  for (genvar s = 0; s < NW; s++) begin : g_stage
    logic          vld_c;
    logic [DW-1:0] rem_c;
    logic [NW-1:0] num_c;
    logic [NW-1:0] quo_c;
    logic [DW-1:0] den_c;
    logic [TW-1:0] tag_c;
    logic [DW:0]   trial;
    logic          ge;

    if (s == 0) begin : g_in
      assign vld_c = vld_i;
      assign rem_c = '0;
      assign num_c = num_i;
      assign quo_c = '0;
      assign den_c = den_i;
      assign tag_c = tag_i;
    end else begin : g_mid
      assign vld_c = vld_q[s-1];
      assign rem_c = rem_q[s-1];
      assign num_c = num_q[s-1];
      assign quo_c = quo_q[s-1];
      assign den_c = den_q[s-1];
      assign tag_c = tag_q[s-1];
    end

    // shift in next numerator bit, subtract if it fits
    assign trial = {rem_c, num_c[NW-1]};
    assign ge    = trial >= {1'b0, den_c};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_c;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= ge ? DW'(trial - {1'b0, den_c}) : trial[DW-1:0];
        num_q[s] <= num_c << 1;
        quo_q[s] <= {quo_c[NW-2:0], ge};
        den_q[s] <= den_c;
        tag_q[s] <= tag_c;
      end
    end
  end

  assign vld_o = vld_q[NW-1];
  assign quo_o = quo_q[NW-1];
  assign tag_o = tag_q[NW-1];

endmodule
`default_nettype wire

// ===== rtl/core/adam_pu_sqrt.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// adam_pu_sqrt
// Pipelined floor square root of a 64-bit value, two radicand bits per stage.
// ----------------------------------------------------------------------------
module adam_pu_sqrt #(
  parameter int unsigned TW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  logic [63:0]   x_i,
  input  logic [TW-1:0] tag_i,
  output logic          vld_o,
  output logic [31:0]   root_o,
  output logic [TW-1:0] tag_o
);

  localparam int unsigned STAGES = 32;

  logic          vld_q [STAGES];
  logic [33:0]   rem_q [STAGES];
  logic [31:0]   res_q [STAGES];
  logic [63:0]   x_q   [STAGES];
  logic [TW-1:0] tag_q [STAGES];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic          vld_c;
    logic [33:0]   rem_c;
    logic [31:0]   res_c;
    logic [63:0]   x_c;
    logic [TW-1:0] tag_c;
    logic [35:0]   cur;
    logic [35:0]   trial;
    logic          ge;

    if (s == 0) begin : g_in
      assign vld_c = vld_i;
      assign rem_c = '0;
      assign res_c = '0;
      assign x_c   = x_i;
      assign tag_c = tag_i;
    end else begin : g_mid
      assign vld_c = vld_q[s-1];
      assign rem_c = rem_q[s-1];
      assign res_c = res_q[s-1];
      assign x_c   = x_q[s-1];
      assign tag_c = tag_q[s-1];
    end

    // next root bit: try 4*res+1 against the partial remainder
    assign cur   = {rem_c, x_c[63:62]};
    assign trial = {2'b00, res_c, 2'b01};
    assign ge    = cur >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_c;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= ge ? 34'(cur - trial) : cur[33:0];
        res_q[s] <= {res_c[30:0], ge};
        x_q[s]   <= x_c << 2;
        tag_q[s] <= tag_c;
      end
    end
  end

  assign vld_o  = vld_q[STAGES-1];
  assign root_o = res_q[STAGES-1];
  assign tag_o  = tag_q[STAGES-1];

endmodule
`default_nettype wire

// ===== rtl/core/adam_pu_moment.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// adam_pu_moment
// Gradient, moment store read-modify-write with forwarding, reset clear pass.
// ----------------------------------------------------------------------------
module adam_pu_moment #(
  parameter int unsigned PARAM_COUNT = 4096,
  parameter int unsigned FRAC_BITS   = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  adv_i,
  input  logic                  fire_i,
  input  adam_pu_pkg::in_word_t word_i,
  input  logic [31:0]           d1_i,
  input  logic [31:0]           d2_i,
  input  logic [15:0]           beta_one_i,
  input  logic [15:0]           beta_two_i,
  output logic                  busy_o,
  output adam_pu_pkg::front_t   front_o
);

  localparam int unsigned AW = (PARAM_COUNT > 1) ? $clog2(PARAM_COUNT) : 1;
  localparam int unsigned IW = adam_pu_pkg::IDX_W;

  logic signed [31:0] mem_m [PARAM_COUNT];
  logic [31:0]        mem_v [PARAM_COUNT];

  // clear pass after reset
  logic          clr_q;
  logic [AW-1:0] clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else if (clr_q) begin
      if (clr_cnt_q == AW'(PARAM_COUNT - 1)) clr_q <= 1'b0;
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  // stage A: product and memory read
  logic               a_vld_q;
  logic               a_ok_q;
  logic [AW-1:0]      a_addr_q;
  logic [IW-1:0]      a_idx_q;
  logic signed [31:0] a_w_q;
  logic [31:0]        a_d1_q, a_d2_q;
  logic signed [63:0] a_prod_q;
  logic               in_ok;

  assign in_ok = 32'(word_i.param_index) < PARAM_COUNT;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (adv_i) begin
      a_vld_q <= fire_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      a_ok_q   <= in_ok;
      a_addr_q <= AW'(word_i.param_index);
      a_idx_q  <= word_i.param_index;
      a_w_q    <= word_i.weight_in;
      a_d1_q   <= d1_i;
      a_d2_q   <= d2_i;
      a_prod_q <= word_i.error_term * word_i.activation;
    end
  end

  // read address follows the word in stage A, or the one about to enter
  logic [AW-1:0]      rd_addr;
  logic signed [31:0] m_rd_q;
  logic [31:0]        v_rd_q;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic signed [31:0] wr_m;
  logic [31:0]        wr_v;

  assign rd_addr = adv_i ? AW'(word_i.param_index) : a_addr_q;

  always_ff @(posedge clk_i) begin
    m_rd_q <= mem_m[rd_addr];
    v_rd_q <= mem_v[rd_addr];
    if (wr_en) begin
      mem_m[wr_addr] <= wr_m;
      mem_v[wr_addr] <= wr_v;
    end
  end

  // gradient and its square
  logic signed [63:0] g_sh;
  logic signed [31:0] g;
  logic signed [63:0] gsq;

  always_comb begin
    g_sh = a_prod_q >>> FRAC_BITS;
    if (g_sh > 64'sd2147483647)       g = 32'sh7FFF_FFFF;
    else if (g_sh < -64'sd2147483648) g = 32'sh8000_0000;
    else                              g = g_sh[31:0];
    gsq = g * g;
  end

  // stage B registers
  logic               b_vld_q;
  logic               b_ok_q;
  logic [AW-1:0]      b_addr_q;
  logic [IW-1:0]      b_idx_q;
  logic signed [31:0] b_w_q;
  logic [31:0]        b_d1_q, b_d2_q;
  logic signed [31:0] b_g_q;
  logic [63:0]        b_gsq_q;
  logic signed [31:0] b_m_old_q;
  logic [31:0]        b_v_old_q;

  logic signed [31:0] m_new;
  logic [31:0]        v_new;
  logic               b_wr;

  // last write, covers a read that raced a write
  logic               lw_vld_q;
  logic [AW-1:0]      lw_addr_q;
  logic signed [31:0] lw_m_q;
  logic [31:0]        lw_v_q;

  // old moment source: zero (bad index), word ahead, last write, or memory
  logic signed [31:0] m_old;
  logic [31:0]        v_old;

  assign b_wr = adv_i & b_vld_q & b_ok_q;

  always_comb begin
    if (!a_ok_q) begin
      m_old = '0;
      v_old = '0;
    end else if (b_vld_q && b_ok_q && (b_addr_q == a_addr_q)) begin
      m_old = m_new;
      v_old = v_new;
    end else if (lw_vld_q && (lw_addr_q == a_addr_q)) begin
      m_old = lw_m_q;
      v_old = lw_v_q;
    end else begin
      m_old = m_rd_q;
      v_old = v_rd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q  <= 1'b0;
      lw_vld_q <= 1'b0;
    end else begin
      if (adv_i) b_vld_q <= a_vld_q;
      if (b_wr)  lw_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      b_ok_q    <= a_ok_q;
      b_addr_q  <= a_addr_q;
      b_idx_q   <= a_idx_q;
      b_w_q     <= a_w_q;
      b_d1_q    <= a_d1_q;
      b_d2_q    <= a_d2_q;
      b_g_q     <= g;
      b_gsq_q   <= 64'(gsq);
      b_m_old_q <= m_old;
      b_v_old_q <= v_old;
    end
    if (b_wr) begin
      lw_addr_q <= b_addr_q;
      lw_m_q    <= m_new;
      lw_v_q    <= v_new;
    end
  end

  // moment update, weights sum to 1.0 in Q0.16
  logic [63:0]        g2_sh;
  logic [31:0]        g2;
  logic signed [17:0] b1s, c1s;
  logic signed [49:0] mp1, mp2;
  logic signed [50:0] msum;
  logic [16:0]        c2;
  logic [49:0]        vp1, vp2, vsum;

  always_comb begin
    g2_sh = b_gsq_q >> FRAC_BITS;
    g2    = (g2_sh[63:32] != '0) ? 32'hFFFF_FFFF : g2_sh[31:0];
    b1s   = signed'({2'b00, beta_one_i});
    c1s   = signed'(18'h1_0000 - {2'b00, beta_one_i});
    mp1   = b1s * b_m_old_q;
    mp2   = c1s * b_g_q;
    msum  = 51'(mp1) + 51'(mp2);
    m_new = msum[47:16];
    c2    = 17'h1_0000 - {1'b0, beta_two_i};
    vp1   = beta_two_i * b_v_old_q;
    vp2   = c2 * g2;
    vsum  = vp1 + vp2;
    v_new = vsum[47:16];
  end

  // write port: clear pass or write-back
  assign wr_en   = clr_q | b_wr;
  assign wr_addr = clr_q ? clr_cnt_q : b_addr_q;
  assign wr_m    = clr_q ? 32'sd0 : m_new;
  assign wr_v    = clr_q ? 32'd0 : v_new;

  assign busy_o      = clr_q;
  assign front_o.vld = b_vld_q;
  assign front_o.idx = b_idx_q;
  assign front_o.w   = b_w_q;
  assign front_o.m   = m_new;
  assign front_o.v   = v_new;
  assign front_o.d1  = b_d1_q;
  assign front_o.d2  = b_d2_q;

endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Adam parameter update unit.
// ----------------------------------------------------------------------------
// A fixed point Adam model in the bench tracks both moment stores, the beta
// powers and the registers. It computes the new weight for every accepted
// word, and each returned word is checked against the oldest prediction.
// Tests run in turn: updates before the first step, first-pass extremes,
// register sweeps, back-pressure, a drain pause and a long random run.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int          DEPTH     = 4096;
  localparam int          DRAIN_CYC = 200;
  localparam int          WDOG_MAX  = 20000;
  localparam logic [31:0] Q_ONE     = 32'h0100_0000;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  adam_pu_pkg::in_word_t  in_data = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  adam_pu_pkg::out_word_t out_data;
  logic                   psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]             paddr = '0;
  logic [31:0]            pwdata = '0;
  logic [31:0]            prdata;
  logic                   pready;

  // model state
  logic [31:0] moment1 [DEPTH];
  logic [31:0] moment2 [DEPTH];
  logic [31:0] pow1, pow2;
  logic [15:0] b1_cfg, b2_cfg;
  logic [24:0] eps_cfg;
  logic [23:0] lr_cfg;
  adam_pu_pkg::out_word_t weight_q[$];

  int  fails = 0;
  int  idle_cycles = 0;
  bit  gaps_on = 1'b1;
  bit  stall_on = 1'b1;
  bit  hold_req = 1'b0;

  adam_parameter_update_unit dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // one Adam step on the model state
  function automatic adam_pu_pkg::out_word_t adam_step(adam_pu_pkg::in_word_t w);
    adam_pu_pkg::out_word_t r;
    longint           g, m, mag, wt;
    longint unsigned  g2, v, d1, d2, mhat, vhat, den, q, x, res, bt;
    if (w.first_of_pass) begin
      pow1 = 32'((64'(pow1) * b1_cfg) >> 16);
      pow2 = 32'((64'(pow2) * b2_cfg) >> 16);
    end
    g = (longint'($signed(w.error_term)) * longint'($signed(w.activation))) >>> 24;
    if (g > 64'sd2147483647) g = 64'sd2147483647;
    if (g < -64'sd2147483648) g = -64'sd2147483648;
    g2 = longint'(g * g) >> 24;
    if (g2 > 64'hFFFF_FFFF) g2 = 64'hFFFF_FFFF;
    m = longint'($signed(moment1[w.param_index]));
    v = 64'(moment2[w.param_index]);
    m = (longint'(b1_cfg) * m + longint'(32'd65536 - b1_cfg) * g) >>> 16;
    v = (64'(b2_cfg) * v + 64'(32'd65536 - b2_cfg) * g2) >> 16;
    moment1[w.param_index] = m[31:0];
    moment2[w.param_index] = v[31:0];
    d1 = 64'h8000_0000 - 64'(pow1);
    d2 = 64'h8000_0000 - 64'(pow2);
    if (d1 == 0) d1 = 64'h8000_0000;
    if (d2 == 0) d2 = 64'h8000_0000;
    mag = (m < 0) ? -m : m;
    mhat = (64'(mag) << 31) / d1;
    if (mhat > 64'hFF_FFFF_FFFF) mhat = 64'hFF_FFFF_FFFF;
    vhat = (v << 31) / d2;
    if (vhat > 64'hFF_FFFF_FFFF) vhat = 64'hFF_FFFF_FFFF;
    // floor square root
    x = vhat << 24;
    res = 0;
    bt = 64'h1 << 62;
    while (bt > x) bt = bt >> 2;
    while (bt != 0) begin
      if (x >= res + bt) begin
        x = x - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    den = res + 64'(eps_cfg);
    if (den == 0) den = 1;
    q = (64'(lr_cfg) * mhat) / den;
    if (q > 64'h2_0000_0000) q = 64'h2_0000_0000;
    wt = longint'($signed(w.weight_in));
    wt = (m < 0) ? wt + longint'(q) : wt - longint'(q);
    if (wt > 64'sd2147483647) wt = 64'sd2147483647;
    if (wt < -64'sd2147483648) wt = -64'sd2147483648;
    r.index_out  = w.param_index;
    r.weight_out = wt[31:0];
    return r;
  endfunction

  // send one word; the prediction is queued at acceptance
  task automatic send_word(adam_pu_pkg::in_word_t w);
    int gap;
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    weight_q.push_back(adam_step(w));
    gap = 0;
    if (gaps_on) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5:  gap = $urandom_range(1, 3);
        6:                 gap = $urandom_range(10, 40);
        default:           gap = 0;
      endcase
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic apb_write(logic [1:0] reg_idx, logic [31:0] val);
    in_valid <= 1'b0;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (reg_idx)
      adam_pu_pkg::REG_BETA_ONE:      b1_cfg  = val[15:0];
      adam_pu_pkg::REG_BETA_TWO:      b2_cfg  = val[15:0];
      adam_pu_pkg::REG_EPSILON:       eps_cfg = val[24:0];
      adam_pu_pkg::REG_LEARNING_RATE: lr_cfg  = val[23:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (weight_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
  endtask

  task automatic set_config(logic [15:0] b1, logic [15:0] b2, logic [24:0] eps,
                            logic [23:0] lr);
    in_valid <= 1'b0;
    wait_drained();
    apb_write(adam_pu_pkg::REG_BETA_ONE, 32'(b1));
    apb_write(adam_pu_pkg::REG_BETA_TWO, 32'(b2));
    apb_write(adam_pu_pkg::REG_EPSILON, 32'(eps));
    apb_write(adam_pu_pkg::REG_LEARNING_RATE, 32'(lr));
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom;
      3:       return Q_ONE;
      4:       return $urandom_range(0, 3) == 0 ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default: return 32'($urandom_range(0, 32'h0400_0000)) - 32'h0200_0000;
    endcase
  endfunction

  function automatic adam_pu_pkg::in_word_t rand_word(int idx_hi);
    adam_pu_pkg::in_word_t w;
    w.param_index   = 12'($urandom_range(0, idx_hi));
    w.error_term    = rand_value();
    w.activation    = ($urandom_range(0, 4) == 0) ? Q_ONE : rand_value();
    w.weight_in     = rand_value();
    w.first_of_pass = ($urandom_range(0, 39) == 0);
    return w;
  endfunction

  function automatic adam_pu_pkg::in_word_t make_word(
    logic [11:0] idx, logic [31:0] e, logic [31:0] a, logic [31:0] wt, bit fp);
    adam_pu_pkg::in_word_t w;
    w.param_index   = idx;
    w.error_term    = e;
    w.activation    = a;
    w.weight_in     = wt;
    w.first_of_pass = fp;
    return w;
  endfunction

  // updates before any pass: no bias correction yet
  task automatic test_no_step_yet();
    send_word(make_word(12'd0, Q_ONE, Q_ONE, 32'h0, 1'b0));
    send_word(make_word(12'd0, Q_ONE, Q_ONE, 32'h0, 1'b0));
    send_word(make_word(12'hFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0));
    send_word(make_word(12'hFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1'b0));
    send_word(make_word(12'd1, 32'h0, 32'h7FFF_FFFF, 32'h1234_5678, 1'b0));
    send_word(make_word(12'd2, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000, 1'b0));
  endtask

  // first pass with extreme values, then small decays and huge steps
  task automatic test_first_pass();
    send_word(make_word(12'd3, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1));
    send_word(make_word(12'd3, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0));
    send_word(make_word(12'hAAA, 32'hFF00_0000, Q_ONE, 32'h0, 1'b0));
    send_word(make_word(12'h555, 32'h0100_0000, Q_ONE, 32'h0, 1'b1));
    set_config(16'hFFFF, 16'hFFFF, 25'h100_0000, 24'hFF_FFFF);
    send_word(make_word(12'd4, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1));
    send_word(make_word(12'd5, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0));
    set_config(16'h0000, 16'h0000, 25'd1, 24'hFF_FFFF);
    send_word(make_word(12'd6, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1));
    send_word(make_word(12'd7, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0));
    send_word(make_word(12'd7, 32'h0000_0001, 32'h0000_0001, 32'h0, 1'b0));
  endtask

  // several register settings with random traffic in between
  task automatic test_config_sweep();
    set_config(16'd58982, 16'd65470, 25'd1, 24'd16777);
    repeat (60) send_word(rand_word(63));
    set_config(16'hFFFF, 16'h0000, 25'h100_0000, 24'd0);
    repeat (60) send_word(rand_word(63));
    set_config(16'h0000, 16'hFFFF, 25'd1, 24'hFF_FFFF);
    repeat (60) send_word(rand_word(DEPTH - 1));
    set_config(16'($urandom), 16'($urandom), 25'($urandom_range(1, 25'h100_0000)),
               24'($urandom));
    repeat (60) send_word(rand_word(15));
    set_config(16'd58982, 16'd65470, 25'd1, 24'd16777);
  endtask

  // long receiver hold-off while the sender keeps going
  task automatic test_backpressure();
    gaps_on  = 1'b0;
    hold_req = 1'b1;
    repeat (200) send_word(rand_word(7));
    gaps_on = 1'b1;
  endtask

  // pause until everything has drained, then carry on
  task automatic test_drain_pause();
    repeat (30) send_word(rand_word(31));
    in_valid <= 1'b0;
    while (weight_q.size() != 0) @(posedge clk_i);
    repeat (30) send_word(rand_word(31));
  endtask

  task automatic test_random();
    for (int n = 0; n < 1300; n++) begin
      // stretches without idling on either side
      gaps_on  = (n % 400) >= 100;
      stall_on = (n % 400) >= 100;
      send_word(rand_word(($urandom_range(0, 3) == 0) ? DEPTH - 1 : 31));
    end
    gaps_on  = 1'b1;
    stall_on = 1'b1;
  endtask

  // receiver: random stalls, plus one long hold on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (!stall_on) begin
        out_ready <= 1'b1;
      end else if ($urandom_range(0, 99) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(10, 60)) @(posedge clk_i);
      end else begin
        out_ready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  // result check against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      if (weight_q.size() == 0) begin
        $error("unexpected word: index %0d weight %h", out_data.index_out,
               out_data.weight_out);
        fails++;
      end else begin
        adam_pu_pkg::out_word_t exp_w;
        exp_w = weight_q.pop_front();
        if (out_data.index_out !== exp_w.index_out) begin
          $error("index_out: expected %0d, got %0d", exp_w.index_out,
                 out_data.index_out);
          fails++;
        end
        if (out_data.weight_out !== exp_w.weight_out) begin
          $error("weight_out: expected %h, got %h", exp_w.weight_out,
                 out_data.weight_out);
          fails++;
        end
      end
    end
  end

  // watchdog on cycles with no word moving
  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_MAX) begin
      $display("adam_parameter_update_unit regression: fail");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < DEPTH; i++) begin
      moment1[i] = '0;
      moment2[i] = '0;
    end
    pow1    = adam_pu_pkg::ONE_Q31;
    pow2    = adam_pu_pkg::ONE_Q31;
    b1_cfg  = adam_pu_pkg::BETA_ONE_RST;
    b2_cfg  = adam_pu_pkg::BETA_TWO_RST;
    eps_cfg = adam_pu_pkg::EPSILON_RST;
    lr_cfg  = adam_pu_pkg::LEARNING_RATE_RST;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_no_step_yet();
    test_first_pass();
    test_config_sweep();
    test_backpressure();
    test_drain_pause();
    test_random();
    in_valid <= 1'b0;
    wait_drained();
    if (fails == 0) begin
      $display("adam_parameter_update_unit regression: pass");
    end else begin
      $display("adam_parameter_update_unit regression: fail");
    end
    $finish;
  end

endmodule
